// ===== sv/vbs_pkg.sv =====
// ----------------------------------------------------------------------------
// vbs_pkg: shared types and constants for the VBS record deblocker
// Stream phases, result codes, segment codes, register map and reset values.
// ----------------------------------------------------------------------------
package vbs_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int REC_LEN_W      = 24;
    localparam int WORD_W         = 32;
    localparam int POS_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [15:0] MAX_REC_RST   = 16'd4096;
    localparam logic [12:0] BLK_WORDS_RST = 13'd5869;
    localparam logic [14:0] MAX_BLK_RST   = 15'd23476;

    // segment descriptor codes (lower half of descriptor)
    localparam logic [15:0] SEG_ONLY  = 16'h0000;
    localparam logic [15:0] SEG_FIRST = 16'h0100;
    localparam logic [15:0] SEG_LAST  = 16'h0200;

    localparam logic [12:0] SEG_LEFT_MAX = 13'h1FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_REC   = 2'd0,
        CFG_BLK_WORDS = 2'd1,
        CFG_MAX_BLK   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_REC_END = 2'd1,
        KIND_EOD     = 2'd2,
        KIND_BLK_ERR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_BDW  = 2'd0,
        PH_SDW  = 2'd1,
        PH_PAY  = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    typedef struct packed {
        logic [15:0] max_rec;
        logic [12:0] blk_words;
        logic [14:0] max_blk;
    } t_cfg;

    typedef struct packed {
        t_phase           phase;
        logic [POS_W-1:0] bpos;
        logic [POS_W-1:0] seg_left;
        logic             seg_ends;
        logic             skip_hdr;
    } t_seg_state;

    typedef struct packed {
        t_kind                kind;
        logic [WORD_W-1:0]    data_word;
        logic [15:0]          word_index;
        logic                 last_of_record;
        logic [REC_LEN_W-1:0] record_length;
        logic                 truncated;
    } t_result;

endpackage

// ===== sv/vbs_cfg.sv =====
// ----------------------------------------------------------------------------
// vbs_cfg: configuration register file
// Three write-only registers, written by index.
// ----------------------------------------------------------------------------
module vbs_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vbs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vbs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output vbs_pkg::t_cfg                       o_cfg
);
    import vbs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_rec   <= MAX_REC_RST;
            r_cfg.blk_words <= BLK_WORDS_RST;
            r_cfg.max_blk   <= MAX_BLK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_REC:   r_cfg.max_rec   <= i_cfg_data;
                CFG_BLK_WORDS: r_cfg.blk_words <= i_cfg_data[12:0];
                CFG_MAX_BLK:   r_cfg.max_blk   <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/vbs_step.sv =====
// ----------------------------------------------------------------------------
// vbs_step: per-word deblocking logic
// Next stream state, record counters and the result for one stream word.
// ----------------------------------------------------------------------------
module vbs_step #(
    parameter int CNT_W = vbs_pkg::COUNT_BITS_DEF
) (
    input  vbs_pkg::t_cfg                   i_cfg,
    input  vbs_pkg::t_seg_state             i_st,
    input  logic [CNT_W-1:0]                i_cnt,
    input  logic                            i_trunc,
    input  logic                            i_mode,
    input  logic [vbs_pkg::WORD_W-1:0]      i_word,
    output vbs_pkg::t_seg_state             o_st,
    output logic [CNT_W-1:0]                o_cnt,
    output logic                            o_trunc,
    output logic                            o_res_valid,
    output vbs_pkg::t_result                o_res
);
    import vbs_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic [15:0]      len;
    logic [15:0]      code;
    logic             first;
    logic             ends;
    logic [15:0]      hdr;
    logic [15:0]      diff;
    logic [POS_W-1:0] pay;
    logic [CNT_W-1:0] cnt_inc;
    logic [POS_W-1:0] left_dec;
    logic             fin;
    logic             last;
    logic             in_limit;
    logic [POS_W-1:0] bp_next;

    assign len   = i_word[31:16];
    assign code  = i_word[15:0];
    assign first = (code == SEG_ONLY) || (code == SEG_FIRST);
    assign ends  = (code == SEG_ONLY) || (code == SEG_LAST);
    assign hdr   = first ? 16'd8 : 16'd4;
    assign diff  = (len >= hdr) ? (len - hdr) : 16'd0;
    // payload words, clamped to the segment counter range
    assign pay   = (diff[15:2] > 14'(SEG_LEFT_MAX)) ? SEG_LEFT_MAX : diff[14:2];

    assign cnt_inc  = (i_cnt != CNT_MAX) ? (i_cnt + 1'b1) : i_cnt;
    assign left_dec = (i_st.seg_left != '0) ? (i_st.seg_left - 1'b1) : i_st.seg_left;
    assign fin      = (left_dec == '0);
    assign last     = fin && i_st.seg_ends;
    assign in_limit = (32'(i_cnt) < 32'(i_cfg.max_rec));
    assign bp_next  = i_st.bpos + 1'b1;

    always_comb begin
        o_st        = i_st;
        o_cnt       = i_cnt;
        o_trunc     = i_trunc;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.record_length = REC_LEN_W'(i_cnt);
        o_res.truncated     = i_trunc;

        if (i_mode) begin
            // end of data: report partial record, clear stream state
            o_res_valid = 1'b1;
            o_res.kind  = KIND_EOD;
            o_st        = '0;
            o_st.phase  = PH_BDW;
            o_cnt       = '0;
            o_trunc     = 1'b0;
        end else begin
            case (i_st.phase)
                PH_BDW: begin
                    if (len > {1'b0, i_cfg.max_blk}) begin
                        o_res_valid          = 1'b1;
                        o_res.kind           = KIND_BLK_ERR;
                        o_res.last_of_record = 1'b1;
                        o_cnt                = '0;
                        o_trunc              = 1'b0;
                        o_st.phase           = PH_SKIP;
                    end else begin
                        o_st.phase = PH_SDW;
                    end
                end
                PH_SDW: begin
                    o_st.seg_left = pay;
                    o_st.seg_ends = ends;
                    o_st.skip_hdr = first;
                    if (first || pay != '0) begin
                        o_st.phase = PH_PAY;
                    end else if (ends) begin
                        o_res_valid          = 1'b1;
                        o_res.kind           = KIND_REC_END;
                        o_res.last_of_record = 1'b1;
                        o_cnt                = '0;
                        o_trunc              = 1'b0;
                    end
                end
                PH_PAY: begin
                    if (i_st.skip_hdr) begin
                        o_st.skip_hdr = 1'b0;
                        if (i_st.seg_left == '0) begin
                            o_st.phase = PH_SDW;
                            if (i_st.seg_ends) begin
                                o_res_valid          = 1'b1;
                                o_res.kind           = KIND_REC_END;
                                o_res.last_of_record = 1'b1;
                                o_cnt                = '0;
                                o_trunc              = 1'b0;
                            end
                        end
                    end else begin
                        o_cnt               = cnt_inc;
                        o_st.seg_left       = left_dec;
                        o_res.record_length = REC_LEN_W'(cnt_inc);
                        if (in_limit) begin
                            o_res_valid          = 1'b1;
                            o_res.kind           = KIND_PAYLOAD;
                            o_res.data_word      = i_word;
                            o_res.word_index     = i_cnt[15:0];
                            o_res.last_of_record = last;
                        end else begin
                            // word past the limit: counted, not emitted
                            o_trunc         = 1'b1;
                            o_res.truncated = 1'b1;
                            if (last) begin
                                o_res_valid          = 1'b1;
                                o_res.kind           = KIND_REC_END;
                                o_res.last_of_record = 1'b1;
                            end
                        end
                        if (fin) begin
                            o_st.phase = PH_SDW;
                            if (last) begin
                                o_cnt   = '0;
                                o_trunc = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            o_st.bpos = bp_next;
            if (bp_next >= i_cfg.blk_words) begin
                o_st.bpos     = '0;
                o_st.phase    = PH_BDW;
                o_st.seg_left = '0;
                o_st.skip_hdr = 1'b0;
                o_st.seg_ends = 1'b0;
            end
        end
    end

endmodule

// ===== sv/vbs_record_deblocker.sv =====
// ----------------------------------------------------------------------------
// vbs_record_deblocker: VBS block stream to record word deblocker
// Walks block and segment descriptors and emits payload words with their
// position in the record, record ends, block size errors and end of data.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+------------------------------------
//   input   | i_in_valid  | o_in_ready  | i_mode, i_word
//   output  | o_out_valid | i_out_ready | o_kind .. o_truncated
//   config  | i_cfg_we    | (none)      | i_cfg_index, i_cfg_data
//
// One word per cycle while the output is not stalled; a word passes the input
// register, then the result register. A word with no result leaves the output
// untouched. Synchronous active-low reset clears stream state and loads
// register defaults. A stalled output holds the word in the input register and
// then drops o_in_ready.
// ----------------------------------------------------------------------------
module vbs_record_deblocker #(
    parameter int COUNT_BITS = vbs_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [vbs_pkg::WORD_W-1:0]          i_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_kind,
    output logic [vbs_pkg::WORD_W-1:0]          o_data_word,
    output logic [15:0]                         o_word_index,
    output logic                                o_last_of_record,
    output logic [vbs_pkg::REC_LEN_W-1:0]       o_record_length,
    output logic                                o_truncated,
    input  logic                                i_cfg_we,
    input  logic [vbs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vbs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import vbs_pkg::*;

    localparam int CNT_W = (COUNT_BITS < REC_LEN_W) ? COUNT_BITS : REC_LEN_W;

    t_cfg              w_cfg;
    logic              r_in_valid;
    logic              r_mode;
    logic [WORD_W-1:0] r_word;
    t_seg_state        r_st;
    t_seg_state        n_st;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_trunc;
    logic              n_trunc;
    logic              w_res_valid;
    t_result           w_res;
    logic              r_out_valid;
    t_result           r_res;
    logic              w_advance;

    vbs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    vbs_step #(
        .CNT_W (CNT_W)
    ) u_step (
        .i_cfg       (w_cfg),
        .i_st        (r_st),
        .i_cnt       (r_cnt),
        .i_trunc     (r_trunc),
        .i_mode      (r_mode),
        .i_word      (r_word),
        .o_st        (n_st),
        .o_cnt       (n_cnt),
        .o_trunc     (n_trunc),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // held word moves on when the result register is free or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode <= i_mode;
            r_word <= i_word;
        end
    end

    // all-zero state is the block descriptor phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= '0;
            r_cnt      <= '0;
            r_trunc    <= 1'b0;
        end else if (w_advance) begin
            r_st    <= n_st;
            r_cnt   <= n_cnt;
            r_trunc <= n_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_res.kind;
    assign o_data_word      = r_res.data_word;
    assign o_word_index     = r_res.word_index;
    assign o_last_of_record = r_res.last_of_record;
    assign o_record_length  = r_res.record_length;
    assign o_truncated      = r_res.truncated;

`ifndef SYNTHESIS
    a_eod_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_mode |=> r_st.phase == PH_BDW && r_st.bpos == '0 && r_cnt == '0)
        else $error("end of data did not clear stream state");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_res_valid && w_res.last_of_record |=> r_cnt == '0 && !r_trunc)
        else $error("record count survived record close");

    a_skip_in_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.skip_hdr |-> r_st.phase == PH_PAY)
        else $error("header skip pending outside payload phase");
`endif

endmodule

// ===== tb/vbs_deblock_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbs_deblock_checker: result predictor and scoreboard for the VBS deblocker
// Watches the input, output and register write ports. Every accepted input
// word is run through a cycle-free model of the deblocker; the result it
// yields, if any, is queued and compared field by field with the next
// accepted output word. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
module vbs_deblock_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_mode,
    input  logic [vbs_pkg::WORD_W-1:0]     i_word,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [1:0]                     i_kind,
    input  logic [vbs_pkg::WORD_W-1:0]     i_data_word,
    input  logic [15:0]                    i_word_index,
    input  logic                           i_last_of_record,
    input  logic [vbs_pkg::REC_LEN_W-1:0]  i_record_length,
    input  logic                           i_truncated,
    input  logic                           i_cfg_we,
    input  logic [vbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_err_count,
    output int                             o_pending
);
    import vbs_pkg::*;

    localparam logic [REC_LEN_W-1:0] REC_CAP = (COUNT_BITS_DEF >= 24) ? 24'hFF_FFFF :
                                               24'((64'd1 << COUNT_BITS_DEF) - 1);

    // register mirror
    logic [15:0]          cfg_max_rec;
    logic [12:0]          cfg_blk_words;
    logic [14:0]          cfg_max_blk;

    // stream state
    t_phase               ph;
    logic [POS_W-1:0]     blk_pos;
    logic [POS_W-1:0]     seg_left;
    logic                 seg_ends;
    logic                 skip_hdr;
    logic [REC_LEN_W-1:0] rec_cnt;
    logic                 rec_trunc;

    t_result              exp_deblocked_q[$];
    int                   n_fail = 0;
    int                   n_pending = 0;

    assign o_err_count = n_fail;
    assign o_pending   = n_pending;

    function automatic t_result make_result(t_kind k, logic [WORD_W-1:0] d,
                                            logic [15:0] idx, logic last);
        t_result r;
        r.kind           = k;
        r.data_word      = d;
        r.word_index     = idx;
        r.last_of_record = last;
        r.record_length  = rec_cnt;
        r.truncated      = rec_trunc;
        return r;
    endfunction

    task automatic clear_stream();
        ph        = PH_BDW;
        blk_pos   = '0;
        seg_left  = '0;
        seg_ends  = 1'b0;
        skip_hdr  = 1'b0;
        rec_cnt   = '0;
        rec_trunc = 1'b0;
    endtask

    // segment with no word left to carry the record end
    task automatic close_empty_segment(inout logic hit, inout t_result res);
        ph = PH_SDW;
        if (seg_ends) begin
            res       = make_result(KIND_REC_END, '0, '0, 1'b1);
            hit       = 1'b1;
            rec_cnt   = '0;
            rec_trunc = 1'b0;
        end
    endtask

    task automatic deblock_word(input logic mode, input logic [WORD_W-1:0] w,
                                output logic hit, output t_result res);
        logic [15:0]          len;
        logic [15:0]          code;
        logic                 first;
        logic [15:0]          hdr;
        logic [15:0]          pay;
        logic [REC_LEN_W-1:0] idx;
        logic                 fin;
        logic                 last;
        hit = 1'b0;
        res = '0;
        if (mode) begin
            res = make_result(KIND_EOD, '0, '0, 1'b0);
            hit = 1'b1;
            clear_stream();
            return;
        end
        case (ph)
            PH_BDW: begin
                if (w[31:16] > {1'b0, cfg_max_blk}) begin
                    res       = make_result(KIND_BLK_ERR, '0, '0, 1'b1);
                    hit       = 1'b1;
                    rec_cnt   = '0;
                    rec_trunc = 1'b0;
                    ph        = PH_SKIP;
                end else begin
                    ph = PH_SDW;
                end
            end
            PH_SDW: begin
                len   = w[31:16];
                code  = w[15:0];
                first = (code == SEG_ONLY) || (code == SEG_FIRST);
                hdr   = first ? 16'd8 : 16'd4;
                pay   = (len >= hdr) ? ((len - hdr) >> 2) : 16'd0;
                if (pay > {3'b000, SEG_LEFT_MAX}) pay = {3'b000, SEG_LEFT_MAX};
                seg_left = pay[POS_W-1:0];
                seg_ends = (code == SEG_ONLY) || (code == SEG_LAST);
                skip_hdr = first;
                if (first || pay != 16'd0) ph = PH_PAY;
                else close_empty_segment(hit, res);
            end
            PH_PAY: begin
                if (skip_hdr) begin
                    skip_hdr = 1'b0;
                    if (seg_left == '0) close_empty_segment(hit, res);
                end else begin
                    idx = rec_cnt;
                    if (rec_cnt < REC_CAP) rec_cnt = rec_cnt + 1'b1;
                    if (seg_left != '0) seg_left = seg_left - 1'b1;
                    fin  = (seg_left == '0);
                    last = fin && seg_ends;
                    if (idx < {8'd0, cfg_max_rec}) begin
                        res = make_result(KIND_PAYLOAD, w, idx[15:0], last);
                        hit = 1'b1;
                    end else begin
                        // past the record buffer: counted only
                        rec_trunc = 1'b1;
                        if (last) begin
                            res = make_result(KIND_REC_END, '0, '0, 1'b1);
                            hit = 1'b1;
                        end
                    end
                    if (fin) begin
                        ph = PH_SDW;
                        if (last) begin
                            rec_cnt   = '0;
                            rec_trunc = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        blk_pos = blk_pos + 1'b1;
        if (blk_pos >= cfg_blk_words) begin
            // block boundary: any open segment is cut, record carries on
            blk_pos  = '0;
            ph       = PH_BDW;
            seg_left = '0;
            skip_hdr = 1'b0;
            seg_ends = 1'b0;
        end
    endtask

    task automatic report(string what, t_result want, t_result got);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%0t ERROR %s: exp kind=%0d data=%h idx=%0d last=%b len=%0d trunc=%b",
                     $realtime, what, want.kind, want.data_word, want.word_index,
                     want.last_of_record, want.record_length, want.truncated);
            $display("%0t       got kind=%0d data=%h idx=%0d last=%b len=%0d trunc=%b",
                     $realtime, got.kind, got.data_word, got.word_index,
                     got.last_of_record, got.record_length, got.truncated);
        end
    endtask

    always @(posedge i_clk) begin : p_watch
        t_result got;
        t_result want;
        t_result pred;
        logic    hit;
        if (!i_rst_n) begin
            clear_stream();
            cfg_max_rec   = MAX_REC_RST;
            cfg_blk_words = BLK_WORDS_RST;
            cfg_max_blk   = MAX_BLK_RST;
            exp_deblocked_q.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MAX_REC:   cfg_max_rec   = i_cfg_data;
                    CFG_BLK_WORDS: cfg_blk_words = i_cfg_data[12:0];
                    CFG_MAX_BLK:   cfg_max_blk   = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_out_valid === 1'b1 && i_out_ready) begin
                got.kind           = t_kind'(i_kind);
                got.data_word      = i_data_word;
                got.word_index     = i_word_index;
                got.last_of_record = i_last_of_record;
                got.record_length  = i_record_length;
                got.truncated      = i_truncated;
                if (exp_deblocked_q.size() == 0) begin
                    report("unexpected word", '0, got);
                end else begin
                    want = exp_deblocked_q.pop_front();
                    if (got.kind !== want.kind || got.data_word !== want.data_word ||
                        got.word_index !== want.word_index ||
                        got.last_of_record !== want.last_of_record ||
                        got.record_length !== want.record_length ||
                        got.truncated !== want.truncated)
                        report("mismatch", want, got);
                end
            end
            if (i_in_valid && i_in_ready === 1'b1) begin
                deblock_word(i_mode, i_word, hit, pred);
                if (hit) exp_deblocked_q.push_back(pred);
            end
        end
        n_pending = exp_deblocked_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the VBS record deblocker
// Directed block streams cover limits, segment codes, short and clamped
// segments, oversized blocks and end of data; then random VBS streams run
// under several register settings with random gaps on both sides, a long
// output stall and a mid-stream sender pause. Checking lives in the checker.
// ----------------------------------------------------------------------------
module testbench;
    import vbs_pkg::*;

    localparam logic [15:0] SEG_MIDDLE = 16'h0300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic [WORD_W-1:0]     word;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            kind;
    logic [WORD_W-1:0]     data_word;
    logic [15:0]           word_index;
    logic                  last_of_record;
    logic [REC_LEN_W-1:0]  record_length;
    logic                  truncated;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    err_count;
    int                    pending;

    int                    snd_gap_max = 0;
    int                    rcv_gap_max = 0;
    bit                    hold_req = 1'b0;

    // stream generator position (guide only; the checker tracks the truth)
    int                    strm_pos = 0;
    int                    strm_blk = 1;
    int                    strm_mb = 0;
    int                    strm_sent = 0;
    bit                    strm_open = 1'b0;

    always #5 clk = ~clk;

    vbs_record_deblocker u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_mode           (mode),
        .i_word           (word),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_kind           (kind),
        .o_data_word      (data_word),
        .o_word_index     (word_index),
        .o_last_of_record (last_of_record),
        .o_record_length  (record_length),
        .o_truncated      (truncated),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    vbs_deblock_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_mode           (mode),
        .i_word           (word),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_kind           (kind),
        .i_data_word      (data_word),
        .i_word_index     (word_index),
        .i_last_of_record (last_of_record),
        .i_record_length  (record_length),
        .i_truncated      (truncated),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_err_count      (err_count),
        .o_pending        (pending)
    );

    // entered at a falling edge; leaves valid high so the next word can follow
    task automatic send_word(input logic m, input logic [WORD_W-1:0] w);
        int n;
        n = $urandom_range(0, snd_gap_max);
        if (n != 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        word     <= w;
        do @(posedge clk); while (in_ready !== 1'b1);
        @(negedge clk);
        strm_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        // words with no result may still be in the pipeline
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input int max_rec, input int blk_words, input int max_blk);
        cfg_write(CFG_MAX_REC, 16'(max_rec));
        cfg_write(CFG_BLK_WORDS, {3'($urandom), 13'(blk_words)});
        cfg_write(CFG_MAX_BLK, {1'($urandom), 15'(max_blk)});
        strm_blk = (blk_words == 0) ? 1 : blk_words;
        strm_mb  = max_blk;
    endtask

    function automatic int pick_gap();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 15;
        endcase
    endfunction

    task automatic set_gaps();
        snd_gap_max = pick_gap();
        rcv_gap_max = pick_gap();
    endtask

    task automatic put_word(input logic [WORD_W-1:0] w);
        send_word(1'b0, w);
        strm_pos++;
        if (strm_pos >= strm_blk) strm_pos = 0;
    endtask

    task automatic put_eod();
        send_word(1'b1, $urandom);
        strm_pos  = 0;
        strm_open = 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] payload_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_bdw();
        int len;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(strm_mb + 1, 65535);
        else if ($urandom_range(0, 3) == 0) len = strm_mb;
        else len = $urandom_range(0, strm_mb);
        put_word({16'(len), 16'($urandom)});
    endtask

    task automatic send_segment();
        int          room;
        int          p;
        int          k;
        logic [15:0] code;
        logic [15:0] len;
        logic        first;
        room = strm_blk - strm_pos - 1;
        if (!strm_open) code = $urandom_range(0, 1) ? SEG_ONLY : SEG_FIRST;
        else code = ($urandom_range(0, 2) == 0) ? SEG_LAST : SEG_MIDDLE;
        if ($urandom_range(0, 11) == 0) code = 16'($urandom);
        first = (code == SEG_ONLY) || (code == SEG_FIRST);
        p = $urandom_range(0, 6);
        if ($urandom_range(0, 4) != 0 && room - int'(first) >= 0 && p > room - int'(first))
            p = room - int'(first);
        len = 16'((first ? 8 : 4) + 4 * p + $urandom_range(0, 3));
        if ($urandom_range(0, 14) == 0) len = 16'($urandom_range(0, first ? 7 : 3));
        else if ($urandom_range(0, 60) == 0) len = 16'hFFFF;
        put_word({len, code});
        if (first && strm_pos != 0) put_word($urandom);
        // a segment running into the block end is cut there
        for (k = 0; k < p && strm_pos != 0; k++) put_word(payload_word());
        if (code == SEG_ONLY || code == SEG_LAST) strm_open = 1'b0;
        else if (code == SEG_FIRST) strm_open = 1'b1;
    endtask

    task automatic send_stream(input int n_words, input int eod_pct);
        int stop;
        put_eod();  // resync block position
        stop = strm_sent + n_words;
        while (strm_sent < stop) begin
            if ($urandom_range(0, 99) < eod_pct) put_eod();
            else if (strm_pos == 0) send_bdw();
            else send_segment();
        end
    endtask

    // receiver: random stall per word, one long hold on request
    initial begin
        int n;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            n = $urandom_range(0, rcv_gap_max);
            if (hold_req) begin
                n        = 120;
                hold_req = 1'b0;
            end
            if (n != 0) begin
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        in_valid  = 1'b0;
        mode      = 1'b0;
        word      = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_MAX_REC;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_gaps();

        // reset values: short record, block limit at and just past the edge
        send_word(1'b0, {16'd23476, 16'($urandom)});
        send_word(1'b0, {16'd16, SEG_ONLY});
        send_word(1'b0, $urandom);
        send_word(1'b0, 32'h0000_0000);
        send_word(1'b0, 32'hFFFF_FFFF);
        send_word(1'b1, 32'hFFFF_FFFF);
        send_word(1'b0, {16'd23477, 16'($urandom)});
        send_word(1'b1, 32'h0000_0000);
        drain();

        // 16-word blocks, 3-word record buffer
        set_config(3, 16, 200);
        send_word(1'b0, {16'd200, 16'($urandom)});
        send_word(1'b0, {16'd28, SEG_ONLY});       // five words, two dropped
        send_word(1'b0, $urandom);
        repeat (5) send_word(1'b0, $urandom);
        send_word(1'b0, {16'd12, SEG_FIRST});
        send_word(1'b0, $urandom);
        send_word(1'b0, $urandom);
        send_word(1'b0, {16'd4, SEG_MIDDLE});      // unknown code, no payload
        send_word(1'b0, {16'd3, SEG_LAST});        // short, empty segment ends record
        send_word(1'b0, {16'd5, SEG_FIRST});       // short first, header only
        send_word(1'b0, $urandom);
        send_word(1'b0, {16'hFFFF, SEG_LAST});     // clamped, cut at block end
        send_word(1'b0, {16'd201, 16'($urandom)}); // oversized block
        send_word(1'b0, $urandom);
        send_word(1'b1, $urandom);
        drain();

        set_config(65535, 24, 32767);
        set_gaps();
        send_stream(170, 2);
        drain();

        // output held off while the sender keeps pushing
        set_config(2, 40, 1000);
        rcv_gap_max = 3;
        snd_gap_max = 0;
        hold_req    = 1'b1;
        send_stream(170, 2);
        drain();

        set_config(0, 1, 0);
        set_gaps();
        send_stream(40, 5);
        drain();

        set_config(5, 8191, 16000);
        set_gaps();
        send_stream(120, 1);
        drain();

        set_config($urandom_range(1, 8), $urandom_range(6, 64), $urandom_range(0, 32767));
        set_gaps();
        send_stream(120, 3);
        drain();

        set_config($urandom_range(0, 3), 0, $urandom_range(0, 300));
        set_gaps();
        send_stream(40, 5);
        drain();

        // sender pauses mid-stream until all results are out
        set_config(4096, 12, 500);
        set_gaps();
        send_stream(75, 2);
        drain();
        send_stream(75, 2);
        drain();

        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/vbs_pkg.sv
sv/vbs_cfg.sv
sv/vbs_step.sv
sv/vbs_record_deblocker.sv
tb/vbs_deblock_checker.sv
tb/testbench.sv
